>>> rtl/core/palette_gamma_color_lookup_assert.svh
// ----------------------------------------------------------------------------
// palette gamma color lookup assertion macros
// shared concurrent assertion forms, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef PALETTE_GAMMA_COLOR_LOOKUP_ASSERT_SVH
`define PALETTE_GAMMA_COLOR_LOOKUP_ASSERT_SVH

// property that must hold at every edge out of reset
`define PGCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define PGCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pgcl_pkg.sv
// ----------------------------------------------------------------------------
// pgcl_pkg
// shared constants, codes, types and the component widening function
// ----------------------------------------------------------------------------
package pgcl_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int GAMMA_ENTRIES   = 256;
  localparam int GAM_AW          = 8;
  localparam int COMP_W          = 8;
  localparam int RGB_W           = 24;
  localparam int DEPTH_W         = 4;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 4;

  localparam logic [DEPTH_W-1:0] COLOR_DEPTH_RESET = 4'd8;
  localparam logic [DEPTH_W-1:0] COLOR_DEPTH_MAX   = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_DEPTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_MODE   = 1'd1;

  // gray weights, sum/100 as (sum * 5243) >> 19, exact for sum below 25600
  localparam int SUM_W      = 15;
  localparam int RECIP_W    = 13;
  localparam int PROD_W     = SUM_W + RECIP_W;
  localparam int GRAY_SHIFT = 19;
  localparam logic [SUM_W-1:0]   GRAY_RED_WT   = 15'd30;
  localparam logic [SUM_W-1:0]   GRAY_GREEN_WT = 15'd59;
  localparam logic [SUM_W-1:0]   GRAY_BLUE_WT  = 15'd11;
  localparam logic [RECIP_W-1:0] GRAY_RECIP    = 13'd5243;

  typedef enum logic [1:0] {
    REQ_GAMMA   = 2'd0,
    REQ_PALETTE = 2'd1,
    REQ_LOOKUP  = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GRAY_SUM,
    ST_GRAY_DIV,
    ST_GAM_RG,
    ST_GAM_B,
    ST_PAL_WR,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic              en;
    logic [GAM_AW-1:0] addr;
    logic [COMP_W-1:0] data;
  } gam_wr_t;

  typedef struct packed {
    logic              en;
    logic [GAM_AW-1:0] addr_a;
    logic [GAM_AW-1:0] addr_b;
  } gam_rd_t;

  function automatic logic [COMP_W-1:0] widen(input logic [COMP_W-1:0] raw,
                                              input logic [DEPTH_W-1:0] depth);
    logic [DEPTH_W-1:0] d;
    logic [DEPTH_W-1:0] sh;
    logic [COMP_W-1:0]  m;
    d  = (depth > COLOR_DEPTH_MAX) ? COLOR_DEPTH_MAX : depth;
    sh = COLOR_DEPTH_MAX - d;
    m  = 8'hFF >> sh;
    return (raw & m) << sh;
  endfunction

endpackage

>>> rtl/core/pgcl_gamma.sv
// ----------------------------------------------------------------------------
// pgcl_gamma
// gamma table memory, one write and two registered reads, identity until written
// ----------------------------------------------------------------------------
module pgcl_gamma (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pgcl_pkg::gam_wr_t         wr,
  input  pgcl_pkg::gam_rd_t         rd,
  output logic [pgcl_pkg::COMP_W-1:0] rd_data_a,
  output logic [pgcl_pkg::COMP_W-1:0] rd_data_b
);
  import pgcl_pkg::*;

  logic [COMP_W-1:0] mem [GAMMA_ENTRIES];
  logic              vld_r [GAMMA_ENTRIES];
  logic [COMP_W-1:0] data_a_r;
  logic [COMP_W-1:0] data_b_r;
  logic [GAM_AW-1:0] addr_a_r;
  logic [GAM_AW-1:0] addr_b_r;
  logic              vld_a_r;
  logic              vld_b_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      data_a_r <= mem[rd.addr_a];
      data_b_r <= mem[rd.addr_b];
      addr_a_r <= rd.addr_a;
      addr_b_r <= rd.addr_b;
      vld_a_r  <= vld_r[rd.addr_a];
      vld_b_r  <= vld_r[rd.addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < GAMMA_ENTRIES; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // unwritten entries read as their own index
  assign rd_data_a = vld_a_r ? data_a_r : addr_a_r;
  assign rd_data_b = vld_b_r ? data_b_r : addr_b_r;

endmodule

>>> rtl/core/palette_gamma_color_lookup.sv
// ----------------------------------------------------------------------------
// palette_gamma_color_lookup
// palette lookup with gamma correction and optional weighted gray conversion
//
//   channel  ports                      direction  accepted when
//   in       in_valid/in_stall + fields input      in_valid && !in_stall
//   out      out_valid/out_stall + rgb  output     out_valid && !out_stall
//   cfg      cfg_wr_en/index/wdata      input      cfg_wr_en
//
// gamma write: taken from idle with no busy state. palette write: gray sum and
// reciprocal multiply (gray mode only), two gamma reads on a two-port table, palette write.
// lookup: registered palette read, then registered output, held while the output stalls.
// one item in flight; in_stall is high while the sequencer is busy.
// reset clears the per-entry valid bits directly, no clearing pass.
// ----------------------------------------------------------------------------
module palette_gamma_color_lookup (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_req_type,
  input  logic [7:0]                      in_entry_index,
  input  logic [7:0]                      in_red_raw,
  input  logic [7:0]                      in_green_raw,
  input  logic [7:0]                      in_blue_raw,
  input  logic [7:0]                      in_gamma_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [23:0]                     out_pixel_rgb,
  input  logic                            cfg_wr_en,
  input  logic [pgcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pgcl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pgcl_pkg::*;

  state_t             state_r;
  state_t             state_nxt;
  logic [DEPTH_W-1:0] color_depth_r;
  logic               gray_mode_r;

  logic               accept;
  logic               in_range;
  logic               out_free;
  logic               out_load;
  logic               pal_we;
  logic               pal_re;
  gam_wr_t            gam_wr;
  gam_rd_t            gam_rd;
  logic [COMP_W-1:0]  gam_data_a;
  logic [COMP_W-1:0]  gam_data_b;

  logic [COMP_W-1:0]  comp_r [3];
  logic [SUM_W-1:0]   sum_r;
  logic [PROD_W-1:0]  prod;
  logic [PAL_AW-1:0]  pal_addr_r;
  logic               in_range_r;
  logic [COMP_W-1:0]  gam_red_r;
  logic [COMP_W-1:0]  gam_green_r;

  logic [RGB_W-1:0]   pal_mem [PALETTE_ENTRIES];
  logic               pal_vld_r [PALETTE_ENTRIES];
  logic [RGB_W-1:0]   pal_rdata_r;
  logic               pal_vld_rd_r;

  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [RGB_W-1:0]   out_pixel_rgb_r;

  assign accept   = in_valid && !in_stall;
  assign in_range = 32'(in_entry_index) < PALETTE_ENTRIES;
  assign out_free = !out_valid_r || !out_stall;
  assign prod     = PROD_W'(sum_r) * PROD_W'(GRAY_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_depth_r <= COLOR_DEPTH_RESET;
      gray_mode_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_COLOR_DEPTH: color_depth_r <= cfg_wdata;
        CFG_GRAY_MODE:   gray_mode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_req_type)
            REQ_PALETTE: begin
              if (in_range) begin
                state_nxt = gray_mode_r ? ST_GRAY_SUM : ST_GAM_RG;
              end
            end
            REQ_LOOKUP: state_nxt = ST_LOOKUP;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_GRAY_SUM: state_nxt = ST_GRAY_DIV;
      ST_GRAY_DIV: state_nxt = ST_GAM_RG;
      ST_GAM_RG:   state_nxt = ST_GAM_B;
      ST_GAM_B:    state_nxt = ST_PAL_WR;
      ST_PAL_WR:   state_nxt = ST_IDLE;
      ST_LOOKUP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state_r != ST_IDLE);
    gam_wr.en     = accept && (in_req_type == REQ_GAMMA);
    gam_wr.addr   = in_entry_index;
    gam_wr.data   = in_gamma_value;
    gam_rd.en     = (state_r == ST_GAM_RG) || (state_r == ST_GAM_B);
    gam_rd.addr_a = (state_r == ST_GAM_B) ? comp_r[2] : comp_r[0];
    gam_rd.addr_b = comp_r[1];
    pal_we        = (state_r == ST_PAL_WR);
    pal_re        = accept && (in_req_type == REQ_LOOKUP);
    out_load      = (state_r == ST_LOOKUP) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  pgcl_gamma u_gamma (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (gam_wr),
    .rd        (gam_rd),
    .rd_data_a (gam_data_a),
    .rd_data_b (gam_data_b)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      comp_r[0]  <= widen(in_red_raw, color_depth_r);
      comp_r[1]  <= widen(in_green_raw, color_depth_r);
      comp_r[2]  <= widen(in_blue_raw, color_depth_r);
      pal_addr_r <= in_entry_index[PAL_AW-1:0];
      in_range_r <= in_range;
    end
    if (state_r == ST_GRAY_SUM) begin
      sum_r <= SUM_W'(comp_r[0]) * GRAY_RED_WT + SUM_W'(comp_r[1]) * GRAY_GREEN_WT
             + SUM_W'(comp_r[2]) * GRAY_BLUE_WT;
    end
    if (state_r == ST_GRAY_DIV) begin
      comp_r[0] <= prod[GRAY_SHIFT +: COMP_W];
      comp_r[1] <= prod[GRAY_SHIFT +: COMP_W];
      comp_r[2] <= prod[GRAY_SHIFT +: COMP_W];
    end
    if (state_r == ST_GAM_B) begin
      gam_red_r   <= gam_data_a;
      gam_green_r <= gam_data_b;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[pal_addr_r] <= {gam_red_r, gam_green_r, gam_data_a};
    end
    if (pal_re) begin
      pal_rdata_r  <= pal_mem[in_entry_index[PAL_AW-1:0]];
      pal_vld_rd_r <= pal_vld_r[in_entry_index[PAL_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
        pal_vld_r[i] <= 1'b0;
      end
    end else if (pal_we) begin
      pal_vld_r[pal_addr_r] <= 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pixel_rgb_r <= (in_range_r && pal_vld_rd_r) ? pal_rdata_r : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_rgb = out_pixel_rgb_r;

endmodule

>>> rtl/core/pgcl_checker.sv
// ----------------------------------------------------------------------------
// pgcl_checker
// port-level checks on the palette lookup, bound to the top level
// ----------------------------------------------------------------------------
`include "palette_gamma_color_lookup_assert.svh"

module pgcl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_req_type,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] out_pixel_rgb
);
  import pgcl_pkg::*;

  `PGCL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_pixel_rgb), "stalled result changed")
  `PGCL_ASSERT_NEXT(a_lookup_busy, in_valid && !in_stall && (in_req_type == REQ_LOOKUP), in_stall, "lookup did not hold input")
  `PGCL_ASSERT_NEXT(a_gamma_one_cycle, in_valid && !in_stall && (in_req_type == REQ_GAMMA), !in_stall, "gamma write not single cycle")
  `PGCL_ASSERT(a_result_after_busy, $rose(out_valid) |-> $past(in_stall), "result without lookup")

endmodule

bind palette_gamma_color_lookup pgcl_checker u_pgcl_checker (.*);

>>> sim/tb_palette_gamma_color_lookup.sv
// ----------------------------------------------------------------------------
// tb_palette_gamma_color_lookup
// drives gamma writes, palette writes and lookups through the valid/stall
// channels, keeps its own gamma table and palette copy, and compares every
// looked-up color with the oldest pending prediction; color depth and gray
// mode are stepped through their extremes between phases, with random gaps
// on both sides and one long output hold-off
// ----------------------------------------------------------------------------
module tb_palette_gamma_color_lookup;
  import pgcl_pkg::*;

  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam int         LIMIT_CYCLES = 200000;
  localparam int         PHASES       = 10;
  localparam int         PHASE_ITEMS  = 70;
  localparam int         NUM_ROWS     = 23;
  localparam int         SETTLE       = 12;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  idx;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  gval;
    logic        fixed;
    logic [23:0] rgb;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_req_type = '0;
  logic [7:0]            in_entry_index = '0;
  logic [7:0]            in_red_raw = '0;
  logic [7:0]            in_green_raw = '0;
  logic [7:0]            in_blue_raw = '0;
  logic [7:0]            in_gamma_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [23:0]           out_pixel_rgb;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [7:0]  gamma_copy [256];
  logic [23:0] palette_copy [256];
  logic [3:0]  depth_now;
  logic        gray_now;
  logic [23:0] rgb_due [$];
  int          miss_count = 0;
  int          cycle_count = 0;
  bit          calm = 1'b0;
  bit          hold_go = 1'b0;

  int depth_plan [7] = '{0, 1, 15, 9, 8, 0, 1};
  bit gray_plan [7]  = '{0, 1, 0, 1, 1, 1, 0};

  // directed rows at reset settings: depth 8, gray off, identity gamma
  row_t plan [NUM_ROWS] = '{
    '{REQ_LOOKUP,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 24'h000000},
    '{REQ_LOOKUP,  8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 24'h000000},
    '{REQ_PALETTE, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h00, 1'b0, 24'h000000},
    '{REQ_LOOKUP,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 24'hFF0080},
    '{REQ_PALETTE, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0, 24'h000000},
    '{REQ_LOOKUP,  8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 24'h00FFFF},
    '{REQ_UNUSED,  8'h07, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 24'h000000},
    '{REQ_LOOKUP,  8'h07, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 24'h000000},
    '{REQ_GAMMA,   8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
    '{REQ_GAMMA,   8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 24'h000000},
    '{REQ_PALETTE, 8'h01, 8'hFF, 8'h00, 8'hAA, 8'h00, 1'b0, 24'h000000},
    '{REQ_LOOKUP,  8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 24'h00FFAA},
    '{REQ_LOOKUP,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 24'hFF0080},
    '{REQ_GAMMA,   8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 24'h000000},
    '{REQ_GAMMA,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
    '{REQ_PALETTE, 8'h02, 8'h55, 8'hAA, 8'h12, 8'h00, 1'b0, 24'h000000},
    '{REQ_LOOKUP,  8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 24'h55AA12},
    '{REQ_GAMMA,   8'h55, 8'h00, 8'h00, 8'h00, 8'h3C, 1'b0, 24'h000000},
    '{REQ_PALETTE, 8'h03, 8'h55, 8'h55, 8'h55, 8'h00, 1'b0, 24'h000000},
    '{REQ_LOOKUP,  8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 24'h3C3C3C},
    '{REQ_PALETTE, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000},
    '{REQ_LOOKUP,  8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 24'h000000},
    '{REQ_GAMMA,   8'h55, 8'h00, 8'h00, 8'h00, 8'h55, 1'b0, 24'h000000}
  };

  palette_gamma_color_lookup dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_entry_index (in_entry_index),
    .in_red_raw     (in_red_raw),
    .in_green_raw   (in_green_raw),
    .in_blue_raw    (in_blue_raw),
    .in_gamma_value (in_gamma_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_rgb  (out_pixel_rgb),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("palette_gamma_color_lookup test failed");
      $finish;
    end
  end

  // raw component scaled up to 8 bits at the current depth
  function automatic int scale_up(input logic [7:0] raw, input logic [3:0] depth);
    int d;
    d = (depth > 4'd8) ? 8 : int'(depth);
    if (d == 0) return 0;
    return int'((raw & (8'hFF >> (8 - d))) << (8 - d)) & 8'hFF;
  endfunction

  function automatic row_t random_row();
    row_t r;
    int   pick;
    pick    = $urandom_range(0, 99);
    r       = '0;
    if (pick < 15) r.kind = REQ_GAMMA;
    else if (pick < 50) r.kind = REQ_PALETTE;
    else if (pick < 95) r.kind = REQ_LOOKUP;
    else r.kind = REQ_UNUSED;
    if (r.kind == REQ_GAMMA || $urandom_range(0, 3) == 0) r.idx = 8'($urandom_range(0, 255));
    else r.idx = 8'($urandom_range(0, 15));
    r.red   = 8'($urandom);
    r.green = 8'($urandom);
    r.blue  = 8'($urandom);
    r.gval  = 8'($urandom);
    return r;
  endfunction

  // update the gamma table and palette copy and queue the color a lookup must return
  task automatic predict_color(input row_t r);
    int red, green, blue, luma;
    if (r.kind == REQ_GAMMA) begin
      gamma_copy[r.idx] = r.gval;
    end else if (r.kind == REQ_PALETTE) begin
      if (int'(r.idx) < PALETTE_ENTRIES) begin
        red   = scale_up(r.red, depth_now);
        green = scale_up(r.green, depth_now);
        blue  = scale_up(r.blue, depth_now);
        if (gray_now) begin
          luma  = (red * 30 + green * 59 + blue * 11) / 100;
          red   = luma;
          green = luma;
          blue  = luma;
        end
        palette_copy[r.idx] = {gamma_copy[red], gamma_copy[green], gamma_copy[blue]};
      end
    end else if (r.kind == REQ_LOOKUP) begin
      if (r.fixed) rgb_due.push_back(r.rgb);
      else if (int'(r.idx) >= PALETTE_ENTRIES) rgb_due.push_back(24'h0);
      else rgb_due.push_back(palette_copy[r.idx]);
    end
  endtask

  task automatic send_item(input row_t r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= r.kind;
    in_entry_index <= r.idx;
    in_red_raw     <= r.red;
    in_green_raw   <= r.green;
    in_blue_raw    <= r.blue;
    in_gamma_value <= r.gval;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_color(r);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (rgb_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_settings(input logic [3:0] depth, input logic gray);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_COLOR_DEPTH;
    cfg_wdata <= CFG_DATA_W'(depth);
    @(posedge clk);
    cfg_index <= CFG_GRAY_MODE;
    cfg_wdata <= CFG_DATA_W'(gray);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    depth_now = depth;
    gray_now  = gray;
  endtask

  // receiver: short random stall bursts, one long hold-off on request
  initial begin : rx_side
    int n;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall <= 1'b1;
        for (n = 0; n < 60; n++) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : color_check
    logic [23:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (rgb_due.size() == 0) begin
        miss_count++;
        if (miss_count <= 10)
          $display("unexpected item: got %06h with nothing pending", out_pixel_rgb);
      end else begin
        want = rgb_due.pop_front();
        if (out_pixel_rgb !== want) begin
          miss_count++;
          if (miss_count <= 10)
            $display("pixel_rgb mismatch: expected %06h got %06h", want, out_pixel_rgb);
        end
      end
    end
  end

  initial begin : stimulus
    int i, p, k;
    for (i = 0; i < 256; i++) begin
      gamma_copy[i]   = 8'(i);
      palette_copy[i] = 24'h0;
    end
    depth_now = COLOR_DEPTH_RESET;
    gray_now  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (i = 0; i < NUM_ROWS; i++) send_item(plan[i]);
    for (p = 0; p < PHASES; p++) begin
      drain_block();
      if (p < 7) write_settings(4'(depth_plan[p]), gray_plan[p]);
      else write_settings(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      if (p == 1) hold_go = 1'b1;
      calm = (p == PHASES - 1);
      for (k = 0; k < PHASE_ITEMS; k++) send_item(random_row());
    end
    drain_block();
    if (miss_count == 0) begin
      $display("palette_gamma_color_lookup test passed");
    end else begin
      $display("palette_gamma_color_lookup test failed");
    end
    $finish;
  end

endmodule

>>> palette_gamma_color_lookup.f
+incdir+rtl/core
rtl/core/pgcl_pkg.sv
rtl/core/pgcl_gamma.sv
rtl/core/palette_gamma_color_lookup.sv
rtl/core/pgcl_checker.sv
sim/tb_palette_gamma_color_lookup.sv
